>>> sv/fxrsqrt_pkg.sv
// Package for the fixed-point reciprocal square root pipeline.
// Holds the word types, the Q16.16 constants, the seed table and the leading-one search.
// No dependencies.
package fxrsqrt_pkg;

	typedef logic [31:0] word_t;
	typedef logic [16:0] seed_t;
	typedef logic [4:0]  exp_t;

	localparam word_t INF_Q16   = 32'hFFFF_FFFF;
	localparam word_t ONE_Q16   = 32'd65536;
	localparam word_t THREE_Q16 = 32'd3 << 16;
	localparam exp_t  TOP_EXP   = 5'd31;

	// Seed for 2^e: round(2^16 / sqrt(2^e)), except 90 for e = 19
	function automatic seed_t seed_lut(input exp_t e);
		seed_t s;
		begin
			case (e)
				5'd0:  s = 17'd65536;
				5'd1:  s = 17'd46341;
				5'd2:  s = 17'd32768;
				5'd3:  s = 17'd23170;
				5'd4:  s = 17'd16384;
				5'd5:  s = 17'd11585;
				5'd6:  s = 17'd8192;
				5'd7:  s = 17'd5793;
				5'd8:  s = 17'd4096;
				5'd9:  s = 17'd2896;
				5'd10: s = 17'd2048;
				5'd11: s = 17'd1448;
				5'd12: s = 17'd1024;
				5'd13: s = 17'd724;
				5'd14: s = 17'd512;
				5'd15: s = 17'd362;
				5'd16: s = 17'd256;
				5'd17: s = 17'd181;
				5'd18: s = 17'd128;
				5'd19: s = 17'd90;
				5'd20: s = 17'd64;
				5'd21: s = 17'd45;
				5'd22: s = 17'd32;
				5'd23: s = 17'd23;
				5'd24: s = 17'd16;
				5'd25: s = 17'd11;
				5'd26: s = 17'd8;
				5'd27: s = 17'd6;
				5'd28: s = 17'd4;
				5'd29: s = 17'd3;
				5'd30: s = 17'd2;
				5'd31: s = 17'd1;
				default: s = 17'd0;
			endcase
			return s;
		end
	endfunction

	// Position of the highest set bit, binary search in five steps
	function automatic exp_t top_bit(input word_t v);
		exp_t        pos;
		logic [15:0] h16;
		logic [7:0]  h8;
		logic [3:0]  h4;
		logic [1:0]  h2;
		begin
			pos[4] = |v[31:16];
			h16    = pos[4] ? v[31:16] : v[15:0];
			pos[3] = |h16[15:8];
			h8     = pos[3] ? h16[15:8] : h16[7:0];
			pos[2] = |h8[7:4];
			h4     = pos[2] ? h8[7:4] : h8[3:0];
			pos[1] = |h4[3:2];
			h2     = pos[1] ? h4[3:2] : h4[1:0];
			pos[0] = h2[1];
			return pos;
		end
	endfunction

endpackage

>>> sv/fixed_point_rsqrt_top.sv
// Top level of the fixed-point reciprocal square root pipeline.
// Uses fxrsqrt_pkg for types, constants, the seed table and the leading-one search.
//
// Usage:
//   Input channel in_valid / in_ready carries operand, an unsigned 32-bit integer.
//   Output channel out_valid / out_ready carries rsqrt_q16 = 1/sqrt(operand) in
//   Q16.16. A zero operand gives all ones, an operand of one gives 65536.
//   One item per cycle is accepted while the receiver keeps up. The depth is
//   set by the seed stages (exponent search, table and fraction shift,
//   interpolation multiply) and by the three dependent 32x32 multiplies of
//   each of the two Newton steps, each multiply in a stage of its own.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated, and bubbles stay in place.
//   Reset clears all valid bits; the payload registers are not reset.
module fixed_point_rsqrt_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fxrsqrt_pkg::word_t  operand,
	output logic                out_valid,
	input  logic                out_ready,
	output fxrsqrt_pkg::word_t  rsqrt_q16
);
	import fxrsqrt_pkg::*;

	// pipeline advance: output empty or being taken
	logic adv;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;

	// special-case flags travel with the item
	logic zero_s1, zero_s2, zero_s3, zero_s4, zero_s5, zero_s6, zero_s7, zero_s8;
	logic one_s1, one_s2, one_s3, one_s4, one_s5, one_s6, one_s7, one_s8;

	word_t x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7;
	exp_t  e_s1;

	// seed path
	seed_t       y0_s2, span_s2;
	logic [15:0] frac_s2;
	word_t       y_s3;

	// Newton step registers
	word_t y_s4, y_s5, y_s6, y_s7, y_s8;
	word_t sq_s4, corr_s5, sq_s7, corr_s8;
	word_t res_s9;

	// combinational intermediates
	exp_t        e_c;
	seed_t       nxt_c;
	word_t       off_c;
	logic [47:0] frac_sh_c;
	logic [32:0] interp_c;
	logic [63:0] sq1_c, xsq1_c, ny1_c, sq2_c, xsq2_c, ny2_c;

	assign adv      = !valid_s9 || out_ready;
	assign in_ready = adv;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// stage 1: exponent search and special-case detect
	assign e_c = top_bit(operand);

	// stage 2: table lookup, span and interpolation fraction
	assign nxt_c     = (e_s1 == TOP_EXP) ? '0 : seed_lut(e_s1 + 5'd1);
	assign off_c     = x_s1 & ~(32'd1 << e_s1);
	assign frac_sh_c = {off_c, 16'd0} >> e_s1;

	// stage 3: interpolate the seed
	assign interp_c = 33'(span_s2) * 33'(frac_s2);

	// Newton step one
	assign sq1_c  = 64'(y_s3) * 64'(y_s3);
	assign xsq1_c = 64'(x_s4) * 64'(sq_s4);
	assign ny1_c  = 64'(y_s5) * 64'(corr_s5);

	// Newton step two
	assign sq2_c  = 64'(y_s6) * 64'(y_s6);
	assign xsq2_c = 64'(x_s7) * 64'(sq_s7);
	assign ny2_c  = 64'(y_s8) * 64'(corr_s8);

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= operand;
			e_s1    <= e_c;
			zero_s1 <= (operand == '0);
			one_s1  <= (operand == 32'd1);

			x_s2    <= x_s1;
			zero_s2 <= zero_s1;
			one_s2  <= one_s1;
			y0_s2   <= seed_lut(e_s1);
			span_s2 <= seed_lut(e_s1) - nxt_c;
			frac_s2 <= frac_sh_c[15:0];

			x_s3    <= x_s2;
			zero_s3 <= zero_s2;
			one_s3  <= one_s2;
			y_s3    <= 32'(y0_s2 - interp_c[32:16]);

			x_s4    <= x_s3;
			zero_s4 <= zero_s3;
			one_s4  <= one_s3;
			y_s4    <= y_s3;
			sq_s4   <= sq1_c[31:0];

			x_s5    <= x_s4;
			zero_s5 <= zero_s4;
			one_s5  <= one_s4;
			y_s5    <= y_s4;
			corr_s5 <= THREE_Q16 - xsq1_c[47:16];

			x_s6    <= x_s5;
			zero_s6 <= zero_s5;
			one_s6  <= one_s5;
			y_s6    <= ny1_c[48:17];

			x_s7    <= x_s6;
			zero_s7 <= zero_s6;
			one_s7  <= one_s6;
			y_s7    <= y_s6;
			sq_s7   <= sq2_c[31:0];

			zero_s8 <= zero_s7;
			one_s8  <= one_s7;
			y_s8    <= y_s7;
			corr_s8 <= THREE_Q16 - xsq2_c[47:16];

			// output register with special-case override
			if (zero_s8) begin
				res_s9 <= INF_Q16;
			end else if (one_s8) begin
				res_s9 <= ONE_Q16;
			end else begin
				res_s9 <= ny2_c[48:17];
			end
		end
	end

	assign out_valid = valid_s9;
	assign rsqrt_q16 = res_s9;

endmodule
